>>> src/gc_victim_block_selector_defines.svh
// Assertion macros shared by the victim selector RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef GC_VICTIM_BLOCK_SELECTOR_DEFINES_SVH
`define GC_VICTIM_BLOCK_SELECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define GCVBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCVBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GCVBS_ASSERT_SAME(lbl, ante, cons, msg)
`define GCVBS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/gcvbs_pkg.sv
package gcvbs_pkg;

    // Default sizing of the block table.
    localparam int unsigned NUM_BLOCKS_DEF      = 1024;
    localparam int unsigned PAGES_PER_BLOCK_DEF = 256;
    localparam int unsigned TIME_WIDTH_DEF      = 32;

    // Fixed field widths of the channels.
    localparam int unsigned BLOCK_IDX_W = 10;
    localparam int unsigned VALID_PG_W  = 9;
    localparam int unsigned IN_TIME_W   = 32;
    localparam int unsigned RND_W       = 31;
    localparam int unsigned TIE_CNT_W   = 11;
    localparam int unsigned WEIGHT_W    = 8;
    localparam int unsigned DIV_CNT_W   = $clog2(RND_W);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

    // Request codes.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [BLOCK_IDX_W-1:0] block_index;
        logic [VALID_PG_W-1:0]  valid_pages;
        logic                   not_collectable;
        logic [IN_TIME_W-1:0]   cook_until;
        logic [IN_TIME_W-1:0]   now_time;
        logic [RND_W-1:0]       random_value;
    } in_item_t;

    typedef struct packed {
        logic [BLOCK_IDX_W-1:0] victim_block;
        logic                   found;
        logic [TIE_CNT_W-1:0]   tie_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_LOCATE,
        ST_DONE
    } state_t;

endpackage

>>> src/gc_victim_block_selector.sv
// Greedy garbage-collection victim selector.
// The input channel (s_valid/s_ready/s_data) carries two kinds of transfer. An update
// writes one block table entry (valid page count, free/open flag, cook time); it
// produces no result. A select scans the table for the eligible block of
// least score (score_weight times valid count) and returns one result transfer on
// m_valid/m_ready/m_data: the victim, a found flag and the number of tied blocks.
// The table memory has one read port, so the first pass (least score and tie count)
// and the second pass (locating the chosen tie) each read one entry per cycle, and
// between them a restoring divider reduces the random value modulo the tie count.
// s_ready is high only while the block is idle; one item is worked on at a time.
// The result sits in an output register, so a new item is accepted while it waits.
// If the receiver still stalls when the next select finishes, that select holds its
// result until the register empties.
// After reset a clearing pass writes every table entry back to its reset value (no
// pages, not collectable, cook time zero); no item is accepted meanwhile.
// The score weight is written through cfg_valid/cfg_ready/cfg_data, which is always
// ready, and resets to one. It must only be written while the block is idle.
`include "gc_victim_block_selector_defines.svh"

module gc_victim_block_selector #(
    parameter int unsigned NUM_BLOCKS      = gcvbs_pkg::NUM_BLOCKS_DEF,
    parameter int unsigned PAGES_PER_BLOCK = gcvbs_pkg::PAGES_PER_BLOCK_DEF,
    parameter int unsigned TIME_WIDTH      = gcvbs_pkg::TIME_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcvbs_pkg::WEIGHT_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gcvbs_pkg::in_item_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gcvbs_pkg::out_item_t              m_data
);

    // Index into the table, count of blocks, valid count and score widths.
    localparam int unsigned IDXW  = $clog2(NUM_BLOCKS);
    localparam int unsigned CNTW  = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned VCW   = $clog2(PAGES_PER_BLOCK + 1);
    localparam int unsigned SCW   = gcvbs_pkg::WEIGHT_W + VCW;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_BLOCKS - 1);
    localparam logic [VCW-1:0]  MAX_VC   = VCW'(PAGES_PER_BLOCK);

    typedef struct packed {
        logic                  skip;
        logic [VCW-1:0]        vc;
        logic [TIME_WIDTH-1:0] cook;
    } entry_t;

    // Block table: one memory word holds the whole entry of a block.
    entry_t mem [NUM_BLOCKS];

    gcvbs_pkg::state_t state_reg, state_next;

    logic [gcvbs_pkg::WEIGHT_W-1:0] weight_reg;

    // Scan address and read pipeline.
    logic [IDXW-1:0]       addr_reg;
    logic                  iss_reg;
    logic                  rd_vld_reg;
    entry_t                rd_data_reg;
    logic [IDXW-1:0]       rd_idx_reg;

    // Request operands captured when a select is accepted.
    logic [TIME_WIDTH-1:0]       now_reg;
    logic [gcvbs_pkg::RND_W-1:0] rnd_reg;

    // Results of the first pass.
    logic            any_reg;
    logic [SCW-1:0]  best_reg;
    logic [CNTW-1:0] ties_reg;

    // Divider and second pass.
    logic [CNTW-1:0]                 rem_reg;
    logic [gcvbs_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [CNTW-1:0]                 seen_reg;
    logic [IDXW-1:0]                 victim_reg;

    logic                  m_valid_reg;
    gcvbs_pkg::out_item_t  m_data_reg;

    // Combinational helpers.
    logic           s_accept;
    logic           start_sel;
    logic           scanning;
    logic           scan_done;
    logic           elig;
    logic [SCW-1:0] score;
    logic [CNTW:0]  trial;
    logic [CNTW:0]  ties_ext;
    logic [CNTW-1:0] rem_step;
    logic           out_load;
    logic           mem_we;
    logic [IDXW-1:0] mem_waddr;
    entry_t         mem_wdata;
    logic [VCW-1:0] vc_clamped;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign start_sel = s_accept && (s_data.req_type == gcvbs_pkg::REQ_SELECT);
    assign scanning  = (state_reg == gcvbs_pkg::ST_SCAN) || (state_reg == gcvbs_pkg::ST_LOCATE);
    assign scan_done = scanning && !iss_reg && !rd_vld_reg;

    // Eligibility and score of the entry just read; one multiplier, one compare.
    assign elig  = !rd_data_reg.skip && (rd_data_reg.cook <= now_reg);
    assign score = SCW'(weight_reg) * SCW'(rd_data_reg.vc);

    // One restoring division step: the next bit of the random value enters the remainder.
    assign ties_ext = {1'b0, ties_reg};
    assign trial    = {rem_reg, rnd_reg[gcvbs_pkg::RND_W-1]};
    assign rem_step = (trial >= ties_ext) ? CNTW'(trial - ties_ext) : CNTW'(trial);

    assign vc_clamped = (32'(s_data.valid_pages) > 32'(PAGES_PER_BLOCK))
                        ? MAX_VC : VCW'(s_data.valid_pages);

    // Next state and handshake outputs.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            gcvbs_pkg::ST_CLEAR: begin
                if (addr_reg == LAST_IDX) begin
                    state_next = gcvbs_pkg::ST_IDLE;
                end
            end
            gcvbs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (start_sel) begin
                    state_next = gcvbs_pkg::ST_SCAN;
                end
            end
            gcvbs_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = any_reg ? gcvbs_pkg::ST_DIV : gcvbs_pkg::ST_DONE;
                end
            end
            gcvbs_pkg::ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = gcvbs_pkg::ST_LOCATE;
                end
            end
            gcvbs_pkg::ST_LOCATE: begin
                if (scan_done) begin
                    state_next = gcvbs_pkg::ST_DONE;
                end
            end
            gcvbs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = gcvbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gcvbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gcvbs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Table write port: the clearing pass, or an update whose index is in range.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '{skip: 1'b1, vc: '0, cook: '0};
        if (state_reg == gcvbs_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (s_accept && (s_data.req_type == gcvbs_pkg::REQ_UPDATE) &&
                     (32'(s_data.block_index) < 32'(NUM_BLOCKS))) begin
            mem_we    = 1'b1;
            mem_waddr = IDXW'(s_data.block_index);
            mem_wdata = '{skip: s_data.not_collectable,
                          vc:   vc_clamped,
                          cook: TIME_WIDTH'(s_data.cook_until)};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            iss_reg     <= 1'b0;
            rd_vld_reg  <= 1'b0;
            weight_reg  <= gcvbs_pkg::WEIGHT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                weight_reg <= cfg_data;
            end
            rd_vld_reg <= scanning && iss_reg;
            if (state_reg == gcvbs_pkg::ST_CLEAR) begin
                addr_reg <= addr_reg + 1'b1;
            end else if (start_sel ||
                         (state_reg == gcvbs_pkg::ST_DIV && div_cnt_reg == '0)) begin
                addr_reg <= '0;
                iss_reg  <= 1'b1;
            end else if (scanning && iss_reg) begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == LAST_IDX) begin
                    iss_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath of the two passes and the divider.
    always_ff @(posedge aclk) begin
        if (start_sel) begin
            now_reg    <= TIME_WIDTH'(s_data.now_time);
            rnd_reg    <= s_data.random_value;
            any_reg    <= 1'b0;
            best_reg   <= '0;
            ties_reg   <= '0;
            victim_reg <= '0;
        end
        unique case (state_reg)
            gcvbs_pkg::ST_SCAN: begin
                if (rd_vld_reg && elig) begin
                    if (!any_reg || score < best_reg) begin
                        any_reg  <= 1'b1;
                        best_reg <= score;
                        ties_reg <= CNTW'(1);
                    end else if (score == best_reg) begin
                        ties_reg <= ties_reg + 1'b1;
                    end
                end
                if (scan_done) begin
                    rem_reg     <= '0;
                    div_cnt_reg <= gcvbs_pkg::DIV_CNT_W'(gcvbs_pkg::RND_W - 1);
                end
            end
            gcvbs_pkg::ST_DIV: begin
                rem_reg     <= rem_step;
                rnd_reg     <= rnd_reg << 1;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                seen_reg    <= '0;
            end
            gcvbs_pkg::ST_LOCATE: begin
                // The seen count only rises, so it meets the chosen position once.
                if (rd_vld_reg && elig && score == best_reg) begin
                    if (seen_reg == rem_reg) begin
                        victim_reg <= rd_idx_reg;
                    end
                    seen_reg <= seen_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_data_reg.victim_block <= gcvbs_pkg::BLOCK_IDX_W'(victim_reg);
            m_data_reg.found        <= any_reg;
            m_data_reg.tie_count    <= gcvbs_pkg::TIE_CNT_W'(ties_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The divider must leave a tie position below the tie count.
    `GCVBS_ASSERT_SAME(a_pick_in_range, state_reg == gcvbs_pkg::ST_LOCATE, rem_reg < ties_reg, "chosen tie position not below tie count")
    // The second pass can never meet more ties than the first pass counted.
    `GCVBS_ASSERT_SAME(a_seen_bounded, state_reg == gcvbs_pkg::ST_LOCATE, seen_reg <= ties_reg, "second pass met more ties than counted")
    // An accepted select starts the first pass from block zero.
    `GCVBS_ASSERT_NEXT(a_select_starts_scan, start_sel, (state_reg == gcvbs_pkg::ST_SCAN) && (addr_reg == '0) && iss_reg, "select did not start the scan")

endmodule

>>> bench/tb_gc_victim_block_selector.sv
module tb_gc_victim_block_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import gcvbs_pkg::*;

    localparam int BLOCKS          = NUM_BLOCKS_DEF;
    localparam int PAGE_LIMIT      = PAGES_PER_BLOCK_DEF;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    // A generous ceiling is needed, since a select scans the whole block table.
    localparam int CYCLE_LIMIT     = 4_000_000;
    // Long enough for two selects to finish behind a stalled receiver, so that the
    // output register fills and the input channel is stalled in turn.
    localparam int LONG_HOLD       = 7000;
    // This pause lets an update still in flight finish.
    localparam int UPDATE_SETTLE   = 16;
    localparam int END_SETTLE      = 64;
    localparam int DIRECTED_ROWS   = 24;
    localparam int WEIGHT_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 52;

    // A directed row either offers one input item or rewrites the score weight.
    typedef enum logic {ROW_ITEM, ROW_WEIGHT} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   req;
        logic [BLOCK_IDX_W-1:0] blk;
        logic [VALID_PG_W-1:0]  pages;
        logic                   skip;
        logic [IN_TIME_W-1:0]   cook;
        logic [IN_TIME_W-1:0]   now;
        logic [RND_W-1:0]       rnd;
        logic [WEIGHT_W-1:0]    weight;
        logic                   typed;
        logic [BLOCK_IDX_W-1:0] want_victim;
        logic                   want_found;
        logic [TIE_CNT_W-1:0]   want_ties;
    } stim_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WEIGHT_W-1:0] cfg_data  = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;

    // Our own copy of the block table and the weight register.
    logic [VALID_PG_W-1:0] pages_held [BLOCKS];
    bit                    skip_held  [BLOCKS];
    logic [IN_TIME_W-1:0]  cook_held  [BLOCKS];
    logic [WEIGHT_W-1:0]   weight_held;

    // Victim choices still owed by the block, oldest first.
    out_item_t victims_due [$];
    out_item_t due_now;

    int mismatches    = 0;
    int cycles        = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    // While set, neither side inserts idle cycles.
    bit steady        = 1'b0;

    // The directed table. Expected results are typed in only where they are obvious:
    // the empty table after reset, blocks still cooking, and a lone eligible block.
    // All other selects are checked against the predictor.
    stim_row_t directed [DIRECTED_ROWS] = '{
        // Straight after reset every block is flagged free or open, so nothing is found.
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b1, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_UPDATE, 10'd0, 9'd0, 1'b1, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h7FFF_FFFF, 8'd0, 1'b1, 10'd0, 1'b0, 11'd0},
        // Top block, page count beyond the block size, cooking until the latest time.
        '{ROW_ITEM, REQ_UPDATE, 10'd1023, 9'd511, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        // One tick early: the block is still cooking.
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFE,
          31'h0000_0000, 8'd0, 1'b1, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h7FFF_FFFF, 8'd0, 1'b1, 10'd1023, 1'b1, 11'd1},
        '{ROW_ITEM, REQ_UPDATE, 10'd0, 9'd256, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        // Full block against a clamped count: the two tie.
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h0000_0001, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_UPDATE, 10'd512, 9'd257, 1'b0, 32'h0000_0064, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        // Cook time equal to the current time is eligible.
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0064,
          31'h0000_0002, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_UPDATE, 10'd5, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h7FFF_FFFF, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        // Weight zero: every eligible block ties.
        '{ROW_WEIGHT, REQ_UPDATE, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h0000_0003, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0006, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_WEIGHT, REQ_UPDATE, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd255, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_UPDATE, 10'd5, 9'd0, 1'b1, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_UPDATE, 10'd512, 9'd255, 1'b0, 32'h0000_0064, 32'h0000_0000,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h0000_0000, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        // Alternating bit patterns in every field.
        '{ROW_ITEM, REQ_UPDATE, 10'h2AA, 9'h155, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555,
          31'h2AAA_AAAA, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'h155, 9'h0AA, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA,
          31'h5555_5555, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_WEIGHT, REQ_UPDATE, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'h0000_0000,
          31'h0000_0000, 8'd1, 1'b0, 10'd0, 1'b0, 11'd0},
        '{ROW_ITEM, REQ_SELECT, 10'd0, 9'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
          31'h5555_5555, 8'd0, 1'b0, 10'd0, 1'b0, 11'd0}
    };

    gc_victim_block_selector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // A block may be chosen only if it is neither free nor open and has finished cooking.
    function automatic bit collectable(input int blk, input logic [IN_TIME_W-1:0] now);
        return !skip_held[blk] && (cook_held[blk] <= now);
    endfunction

    // An update stores one table entry; page counts above the block size are clamped.
    function automatic void record_update(input in_item_t it);
        if (it.block_index < BLOCKS) begin
            if (it.valid_pages > PAGE_LIMIT)
                pages_held[it.block_index] = VALID_PG_W'(PAGE_LIMIT);
            else
                pages_held[it.block_index] = it.valid_pages;
            skip_held[it.block_index] = it.not_collectable;
            cook_held[it.block_index] = it.cook_until;
        end
    endfunction

    // Greedy choice: least weighted valid count, then the tie at position
    // (random value mod tie count) in index order. An empty set yields all zeros.
    function automatic out_item_t pick_victim(input logic [IN_TIME_W-1:0] now,
                                              input logic [RND_W-1:0] rnd);
        out_item_t res;
        logic [31:0] best;
        logic [31:0] score;
        int ties;
        int pick;
        int seen;
        res  = '0;
        best = '0;
        ties = 0;
        seen = 0;
        for (int i = 0; i < BLOCKS; i++) begin
            if (collectable(i, now)) begin
                score = 32'(weight_held) * 32'(pages_held[i]);
                if (ties == 0 || score < best) begin
                    best = score;
                    ties = 1;
                end else if (score == best) begin
                    ties++;
                end
            end
        end
        if (ties != 0) begin
            pick = int'(rnd) % ties;
            for (int i = 0; i < BLOCKS; i++) begin
                if (collectable(i, now) &&
                    (32'(weight_held) * 32'(pages_held[i])) == best) begin
                    if (seen == pick) begin
                        res.victim_block = i[BLOCK_IDX_W-1:0];
                        res.found        = 1'b1;
                        res.tie_count    = ties[TIE_CNT_W-1:0];
                        break;
                    end
                    seen++;
                end
            end
        end
        return res;
    endfunction

    // Idle stretches: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    // Random items concentrate on a small pool of blocks so that selects see a
    // populated table with plenty of ties, with a spread over the whole range too.
    function automatic in_item_t random_item();
        in_item_t it;
        int r;
        it.req_type = ($urandom_range(0, 99) < 30) ? REQ_SELECT : REQ_UPDATE;
        r = $urandom_range(0, 99);
        if (r < 70)
            it.block_index = BLOCK_IDX_W'($urandom_range(0, 15));
        else if (r < 85)
            it.block_index = BLOCK_IDX_W'($urandom_range(BLOCKS - 16, BLOCKS - 1));
        else
            it.block_index = BLOCK_IDX_W'($urandom_range(0, BLOCKS - 1));
        r = $urandom_range(0, 99);
        if (r < 60)
            it.valid_pages = VALID_PG_W'($urandom_range(0, 7));
        else if (r < 85)
            it.valid_pages = VALID_PG_W'($urandom_range(0, PAGE_LIMIT));
        else
            it.valid_pages = VALID_PG_W'($urandom_range(PAGE_LIMIT + 1, 511));
        it.not_collectable = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 70)
            it.cook_until = $urandom_range(0, 1000);
        else if (r < 85)
            it.cook_until = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else
            it.cook_until = $urandom();
        r = $urandom_range(0, 99);
        if (r < 60)
            it.now_time = $urandom_range(0, 1000);
        else if (r < 80)
            it.now_time = 32'hFFFF_FFFF;
        else
            it.now_time = $urandom();
        if ($urandom_range(0, 1) == 0)
            it.random_value = RND_W'($urandom_range(0, 15));
        else
            it.random_value = RND_W'($urandom());
        return it;
    endfunction

    // Offers one item and waits for its transfer. The expectation is formed at the
    // accepting edge, so it sees exactly the updates that went in before it.
    task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.req_type == REQ_SELECT)
            victims_due.push_back(typed ? want : pick_victim(it.now_time, it.random_value));
        else
            record_update(it);
    endtask

    // The weight may change only when the block is idle: every select has answered,
    // any trailing update has had time to finish, and the input channel is ready.
    task automatic set_weight(input logic [WEIGHT_W-1:0] w);
        s_valid <= 1'b0;
        while (victims_due.size() != 0) @(posedge aclk);
        repeat (UPDATE_SETTLE) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        weight_held = w;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Stimulus: reset, the directed table, then random items under several weights.
    initial begin
        in_item_t  it;
        stim_row_t row;
        out_item_t want;
        logic [WEIGHT_W-1:0] w;
        for (int i = 0; i < BLOCKS; i++) begin
            pages_held[i] = '0;
            skip_held[i]  = 1'b1;
            cook_held[i]  = '0;
        end
        weight_held = WEIGHT_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed[k];
            if (row.kind == ROW_WEIGHT) begin
                set_weight(row.weight);
            end else begin
                it   = {row.req, row.blk, row.pages, row.skip, row.cook, row.now, row.rnd};
                want = {row.want_victim, row.want_found, row.want_ties};
                offer(it, row.typed, want);
            end
        end

        // Weight settings for the random part: both extremes, the reset value and
        // two arbitrary values in between.
        for (int p = 0; p < WEIGHT_PHASES; p++) begin
            unique case (p)
                0: begin
                    w = 8'd255;
                end
                1: begin
                    w = 8'd0;
                end
                3: begin
                    w = WEIGHT_RESET;
                end
                default: begin
                    w = WEIGHT_W'($urandom_range(2, 254));
                end
            endcase
            set_weight(w);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 13 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                it = random_item();
                // The first phase opens with back-to-back selects against a receiver
                // that has stopped taking results, so the output register fills and
                // the input channel has to stall.
                if (p == 0 && n < 6) begin
                    steady      = 1'b1;
                    it.req_type = REQ_SELECT;
                end
                if (p == 0 && n == 0)
                    hold_requests++;
                offer(it, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (victims_due.size() != 0) @(posedge aclk);
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("gc_victim_block_selector test passed");
        else
            $display("gc_victim_block_selector test failed");
        $finish;
    end

    // Result receiver: random stalls, plus the one long hold-off that the stimulus
    // asks for, counted here in its own cycles.
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                n = idle_len();
                m_ready <= (n == 0);
                repeat ((n == 0) ? 1 : n) @(posedge aclk);
            end
        end
    end

    // Every result transfer is matched against the oldest outstanding choice.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (victims_due.size() == 0) begin
                $display("%0t ns: result expected none, got victim %0d found %0d ties %0d",
                         $time, m_data.victim_block, m_data.found, m_data.tie_count);
                mismatches++;
            end else begin
                due_now = victims_due.pop_front();
                check_field("victim_block", 32'(due_now.victim_block),
                            32'(m_data.victim_block));
                check_field("found", 32'(due_now.found), 32'(m_data.found));
                check_field("tie_count", 32'(due_now.tie_count), 32'(m_data.tie_count));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("gc_victim_block_selector test failed");
            $finish;
        end
    end

endmodule

>>> sim.f
+incdir+src
src/gcvbs_pkg.sv
src/gc_victim_block_selector.sv
bench/tb_gc_victim_block_selector.sv
